@@ rtl/assert_macros.svh @@
// assertion macros shared by the decoder rtl
// expects signals named clock and reset in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// consequent required in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/ted_pkg.sv @@
// shared types, character codes and lookup functions for the decoder
// used by ted_core, ted_drain and transfer_encoding_decoder
package ted_pkg;

   // decode modes held in the mode register
   localparam logic [1:0] MODE_PASS = 2'd0;
   localparam logic [1:0] MODE_QP   = 2'd1;
   localparam logic [1:0] MODE_B64  = 2'd2;

   // character codes
   localparam logic [7:0] CH_EQ = 8'h3D;
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;

   // hex value marker for a non-hex character
   localparam logic [4:0] HEX_NONE = 5'd16;

   // base64 lookup markers
   localparam logic [6:0] SEXTET_PAD  = 7'd64;
   localparam logic [6:0] SEXTET_JUNK = 7'd65;

   // up to three results released by one request
   typedef struct packed {
      logic [2:0][7:0] data;
      logic [1:0]      count;
      logic            empty;
      logic            msg_end;
   } burst_type;

   // 0..15 for a hex digit of either case, HEX_NONE otherwise
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      v = HEX_NONE;
      if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
      else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h41 + 8'd10);
      else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h61 + 8'd10);
      return v;
   endfunction

   // 0..63 for the base64 alphabet, SEXTET_PAD for '=', SEXTET_JUNK otherwise
   function automatic logic [6:0] sextet_value(input logic [7:0] c);
      logic [6:0] v;
      v = SEXTET_JUNK;
      if (c >= 8'h41 && c <= 8'h5A) v = 7'(c - 8'h41);
      else if (c >= 8'h61 && c <= 8'h7A) v = 7'(c - 8'h61 + 8'd26);
      else if (c >= 8'h30 && c <= 8'h39) v = 7'(c - 8'h30 + 8'd52);
      else if (c == 8'h2B) v = 7'd62;
      else if (c == 8'h2F) v = 7'd63;
      else if (c == CH_EQ) v = SEXTET_PAD;
      return v;
   endfunction

endpackage

@@ rtl/ted_channels.sv @@
// valid/ready channel interfaces for requests, results and the mode register
// no dependencies
interface ted_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       last_byte;
   modport source (output valid, output in_byte, output last_byte, input ready);
   modport sink (input valid, input in_byte, input last_byte, output ready);
endinterface

interface ted_rsp_if #(parameter int COUNT_WIDTH = 24);
   logic                   valid;
   logic                   ready;
   logic [7:0]             out_byte;
   logic                   byte_valid;
   logic                   run_last;
   logic                   message_end;
   logic [COUNT_WIDTH-1:0] total_bytes;
   modport source (output valid, output out_byte, output byte_valid, output run_last,
      output message_end, output total_bytes, input ready);
   modport sink (input valid, input out_byte, input byte_valid, input run_last,
      input message_end, input total_bytes, output ready);
endinterface

interface ted_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] decode_mode;
   modport source (output valid, output decode_mode, input ready);
   modport sink (input valid, input decode_mode, output ready);
endinterface

@@ rtl/ted_core.sv @@
// decode logic and message state: turns one request into up to three results
// depends on ted_pkg
module ted_core #(
   parameter int COUNT_WIDTH = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   take,
   input  logic [7:0]             in_byte,
   input  logic                   last_byte,
   input  logic [1:0]             decode_mode,
   output ted_pkg::burst_type     burst,
   output logic [COUNT_WIDTH-1:0] count_base
);

   typedef enum logic [1:0] {
      PH_TEXT,
      PH_EQ,
      PH_DIGIT,
      PH_EQ_CR
   } phase_type;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   phase_type              phase_ff, phase_in;
   logic [7:0]             held_ff, held_in;
   logic [17:0]            accum_ff, accum_in;
   logic [1:0]             sextets_ff, sextets_in;
   logic                   padding_ff, padding_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;

   assign count_base = count_ff;

   // next state and released bytes for the request on the inputs
   always_comb begin
      logic [2:0]             n;
      logic [4:0]             hv_c;
      logic [4:0]             hv_h;
      logic [6:0]             sv;
      logic [23:0]            full;
      logic [COUNT_WIDTH+1:0] sum;

      n          = 3'd0;
      hv_c       = ted_pkg::hex_value(in_byte);
      hv_h       = ted_pkg::hex_value(held_ff);
      sv         = ted_pkg::sextet_value(in_byte);
      full       = {accum_ff, sv[5:0]};
      burst      = '0;
      phase_in   = phase_ff;
      held_in    = held_ff;
      accum_in   = accum_ff;
      sextets_in = sextets_ff;
      padding_in = padding_ff;

      case (decode_mode)
         // quoted-printable
         ted_pkg::MODE_QP: begin
            case (phase_ff)
               PH_TEXT: begin
                  if (in_byte == ted_pkg::CH_EQ) begin
                     phase_in = PH_EQ;
                  end else begin
                     phase_in = PH_TEXT;
                     burst.data[n[1:0]] = in_byte;
                     n = n + 3'd1;
                  end
               end
               PH_EQ: begin
                  if (in_byte == ted_pkg::CH_CR) begin
                     phase_in = PH_EQ_CR;
                  end else if (in_byte == ted_pkg::CH_LF) begin
                     phase_in = PH_TEXT;
                  end else if (hv_c != ted_pkg::HEX_NONE) begin
                     held_in  = in_byte;
                     phase_in = PH_DIGIT;
                  end else begin
                     // broken escape: literal '=', then the character as text, or a new escape if it is '='
                     burst.data[n[1:0]] = ted_pkg::CH_EQ;
                     n = n + 3'd1;
                     if (in_byte == ted_pkg::CH_EQ) begin
                        phase_in = PH_EQ;
                     end else begin
                        phase_in = PH_TEXT;
                        burst.data[n[1:0]] = in_byte;
                        n = n + 3'd1;
                     end
                  end
               end
               PH_DIGIT: begin
                  if (hv_c != ted_pkg::HEX_NONE) begin
                     phase_in = PH_TEXT;
                     burst.data[n[1:0]] = {hv_h[3:0], hv_c[3:0]};
                     n = n + 3'd1;
                  end else begin
                     // broken escape: literal '=' and held digit, then text or a new escape on '='
                     burst.data[n[1:0]] = ted_pkg::CH_EQ;
                     n = n + 3'd1;
                     burst.data[n[1:0]] = held_ff;
                     n = n + 3'd1;
                     if (in_byte == ted_pkg::CH_EQ) begin
                        phase_in = PH_EQ;
                     end else begin
                        phase_in = PH_TEXT;
                        burst.data[n[1:0]] = in_byte;
                        n = n + 3'd1;
                     end
                  end
               end
               default: begin
                  // after '=' CR: a LF completes the soft break
                  phase_in = PH_TEXT;
                  if (in_byte == ted_pkg::CH_EQ) begin
                     phase_in = PH_EQ;
                  end else if (in_byte != ted_pkg::CH_LF) begin
                     burst.data[n[1:0]] = in_byte;
                     n = n + 3'd1;
                  end
               end
            endcase
            // flush a pending escape at message end
            if (last_byte) begin
               if (phase_in == PH_EQ) begin
                  burst.data[n[1:0]] = ted_pkg::CH_EQ;
                  n = n + 3'd1;
               end else if (phase_in == PH_DIGIT) begin
                  burst.data[n[1:0]] = ted_pkg::CH_EQ;
                  n = n + 3'd1;
                  burst.data[n[1:0]] = held_in;
                  n = n + 3'd1;
               end
            end
         end
         // base64
         ted_pkg::MODE_B64: begin
            if (!padding_ff) begin
               if (sv == ted_pkg::SEXTET_PAD) begin
                  if (sextets_ff == 2'd2) begin
                     burst.data[0] = accum_ff[11:4];
                     n = 3'd1;
                  end else if (sextets_ff == 2'd3) begin
                     burst.data[0] = accum_ff[17:10];
                     burst.data[1] = accum_ff[9:2];
                     n = 3'd2;
                  end
                  padding_in = 1'b1;
                  accum_in   = '0;
                  sextets_in = 2'd0;
               end else if (sv != ted_pkg::SEXTET_JUNK) begin
                  if (sextets_ff == 2'd3) begin
                     burst.data[0] = full[23:16];
                     burst.data[1] = full[15:8];
                     burst.data[2] = full[7:0];
                     n = 3'd3;
                     accum_in   = '0;
                     sextets_in = 2'd0;
                  end else begin
                     accum_in   = {accum_ff[11:0], sv[5:0]};
                     sextets_in = sextets_ff + 2'd1;
                  end
               end
            end
         end
         // pass-through, also for the unused mode code
         default: begin
            burst.data[0] = in_byte;
            n = 3'd1;
         end
      endcase

      // saturating byte count after this request
      sum = {2'b00, count_ff} + (COUNT_WIDTH+2)'(n);
      if (sum[COUNT_WIDTH+1:COUNT_WIDTH] != 2'b00) count_in = COUNT_MAX;
      else count_in = sum[COUNT_WIDTH-1:0];

      // closing result of the message
      burst.count   = n[1:0];
      burst.msg_end = last_byte;
      if (last_byte && n == 3'd0) begin
         burst.count = 2'd1;
         burst.empty = 1'b1;
      end
   end

   // message state, cleared by reset and by the last request of a message
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_TEXT;
         held_ff    <= '0;
         accum_ff   <= '0;
         sextets_ff <= 2'd0;
         padding_ff <= 1'b0;
         count_ff   <= '0;
      end else if (take) begin
         if (last_byte) begin
            phase_ff   <= PH_TEXT;
            held_ff    <= '0;
            accum_ff   <= '0;
            sextets_ff <= 2'd0;
            padding_ff <= 1'b0;
            count_ff   <= '0;
         end else begin
            phase_ff   <= phase_in;
            held_ff    <= held_in;
            accum_ff   <= accum_in;
            sextets_ff <= sextets_in;
            padding_ff <= padding_in;
            count_ff   <= count_in;
         end
      end
   end

endmodule

@@ rtl/ted_drain.sv @@
// result register: holds one request's results and hands them out in order
// depends on ted_pkg and ted_rsp_if
module ted_drain #(
   parameter int COUNT_WIDTH = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  ted_pkg::burst_type     burst,
   input  logic [COUNT_WIDTH-1:0] count_base,
   output logic                   free,
   ted_rsp_if.source              rsp
);

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   ted_pkg::burst_type     burst_ff;
   logic [COUNT_WIDTH-1:0] base_ff;
   logic                   valid_ff, valid_in;
   logic [1:0]             idx_ff, idx_in;
   logic                   last_res;
   logic [COUNT_WIDTH+1:0] sum;

   assign last_res = (idx_ff == burst_ff.count - 2'd1);
   assign free     = !valid_ff || (rsp.ready && last_res);

   // result fields for the entry being offered
   assign sum             = {2'b00, base_ff} + (COUNT_WIDTH+2)'(idx_ff) + 1'b1;
   assign rsp.valid       = valid_ff;
   assign rsp.out_byte    = burst_ff.empty ? 8'h00 : burst_ff.data[idx_ff];
   assign rsp.byte_valid  = !burst_ff.empty;
   assign rsp.run_last    = last_res;
   assign rsp.message_end = burst_ff.msg_end && last_res;
   always_comb begin
      if (burst_ff.empty) rsp.total_bytes = base_ff;
      else if (sum[COUNT_WIDTH+1:COUNT_WIDTH] != 2'b00) rsp.total_bytes = COUNT_MAX;
      else rsp.total_bytes = sum[COUNT_WIDTH-1:0];
   end

   // occupancy and read index
   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = 2'd0;
      end else if (valid_ff && rsp.ready) begin
         if (last_res) valid_in = 1'b0;
         else idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (load) begin
         burst_ff <= burst;
         base_ff  <= count_base;
      end
   end

endmodule

@@ rtl/transfer_encoding_decoder.sv @@
// the first result of a request is registered and offered in the cycle after the request is taken
// throughput: one request per cycle while each releases at most one result and results are
//   taken; a request releasing more holds the request channel until the result register is free
// reset: synchronous, clears message state, empties the result register and sets pass-through mode
// holds the mode register and joins ted_core and ted_drain; depends on ted_pkg,
//   the channel interfaces and assert_macros.svh
`include "assert_macros.svh"

module transfer_encoding_decoder #(
   parameter int COUNT_WIDTH = 24
) (
   input logic       clock,
   input logic       reset,
   ted_req_if.sink   req_bus,
   ted_rsp_if.source rsp_bus,
   ted_csr_if.sink   csr_bus
);

   logic [1:0]             mode_ff, mode_in;
   logic                   take;
   logic                   load;
   logic                   free;
   ted_pkg::burst_type     burst;
   logic [COUNT_WIDTH-1:0] count_base;

   // mode register, always writable
   assign csr_bus.ready = 1'b1;
   assign mode_in = (csr_bus.valid) ? csr_bus.decode_mode : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ted_pkg::MODE_PASS;
      end else begin
         mode_ff <= mode_in;
      end
   end

   // request handshake
   assign req_bus.ready = free;
   assign take = req_bus.valid && req_bus.ready;
   assign load = take && (burst.count != 2'd0);

   ted_core #(.COUNT_WIDTH(COUNT_WIDTH)) u_core (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .in_byte     (req_bus.in_byte),
      .last_byte   (req_bus.last_byte),
      .decode_mode (mode_ff),
      .burst       (burst),
      .count_base  (count_base)
   );

   ted_drain #(.COUNT_WIDTH(COUNT_WIDTH)) u_drain (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .burst      (burst),
      .count_base (count_base),
      .free       (free),
      .rsp        (rsp_bus)
   );

   // checks
   `ASSERT_ALWAYS(a_empty_closes, !(rsp_bus.valid && !rsp_bus.byte_valid) || (rsp_bus.run_last && rsp_bus.message_end), "empty result that does not close the message")
   `ASSERT_ALWAYS(a_end_on_run_last, !(rsp_bus.valid && rsp_bus.message_end) || rsp_bus.run_last, "message end before the last result of a request")
   `ASSERT_ALWAYS(a_count_nonzero, !(rsp_bus.valid && rsp_bus.byte_valid) || (rsp_bus.total_bytes != '0), "data result with zero byte count")
   `ASSERT_NEXT(a_last_gives_result, req_bus.valid && req_bus.ready && req_bus.last_byte, rsp_bus.valid, "last request produced no result")

endmodule

@@ bench/tb_transfer_encoding_decoder.sv @@
// self-checking bench for transfer_encoding_decoder: directed table, then random messages
// in pass-through, quoted-printable and base64 modes; depends on ted_pkg and ted_channels
module tb_transfer_encoding_decoder;

   localparam int CNT_W = 24;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_REQUESTS = 90;
   localparam int SETTLE_CYCLES = 4;
   localparam int DIRECTED_ROWS = 31;

   // mode three is not named in the package, it decodes as pass-through
   localparam logic [1:0] MODE_ALT_PASS = 2'd3;

   typedef enum logic [1:0] {ESC_TEXT, ESC_EQ, ESC_DIGIT, ESC_EQ_CR} esc_phase_type;

   typedef struct packed {
      logic [7:0]       out_byte;
      logic             byte_valid;
      logic             run_last;
      logic             message_end;
      logic [CNT_W-1:0] total_bytes;
   } dec_result_type;

   typedef struct packed {
      logic           is_cfg;
      logic [1:0]     mode;
      logic [7:0]     ch;
      logic           last;
      logic           typed;
      dec_result_type want;
   } stim_row_type;

   logic clock;
   logic reset;

   ted_req_if                        req ();
   ted_rsp_if #(.COUNT_WIDTH(CNT_W)) rsp ();
   ted_csr_if                        csr ();

   transfer_encoding_decoder #(.COUNT_WIDTH(CNT_W)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req),
      .rsp_bus (rsp),
      .csr_bus (csr)
   );

   // decoder state as the bench sees it
   logic [1:0]       mode_reg;
   esc_phase_type    esc_phase;
   logic [7:0]       held_digit;
   logic [17:0]      sextets;
   logic [1:0]       sextet_cnt;
   logic             pad_seen;
   logic [CNT_W-1:0] byte_cnt;

   dec_result_type step_results[$];
   dec_result_type decoded_queue[$];
   logic [7:0]     msg_chars[$];

   int mismatches = 0;
   int cycle_count = 0;
   int burst_left = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hex digit value of either case, -1 for anything else
   function automatic int hex_digit(input logic [7:0] c);
      if (c inside {[8'h30:8'h39]}) return int'(c) - 'h30;
      if (c inside {[8'h41:8'h46]}) return int'(c) - 'h41 + 10;
      if (c inside {[8'h61:8'h66]}) return int'(c) - 'h61 + 10;
      return -1;
   endfunction

   // base64 alphabet value, 64 for the pad character, -1 for junk
   function automatic int b64_sextet(input logic [7:0] c);
      if (c inside {[8'h41:8'h5A]}) return int'(c) - 'h41;
      if (c inside {[8'h61:8'h7A]}) return int'(c) - 'h61 + 26;
      if (c inside {[8'h30:8'h39]}) return int'(c) - 'h30 + 52;
      if (c == 8'h2B) return 62;
      if (c == 8'h2F) return 63;
      if (c == ted_pkg::CH_EQ) return 64;
      return -1;
   endfunction

   // one decoded byte, counted with saturation
   function automatic void push_byte(input logic [7:0] b);
      dec_result_type r;
      if (byte_cnt != '1) byte_cnt = byte_cnt + 1'b1;
      r = '{out_byte: b, byte_valid: 1'b1, run_last: 1'b0, message_end: 1'b0,
            total_bytes: byte_cnt};
      step_results.push_back(r);
   endfunction

   // ordinary quoted-printable text, '=' opens an escape
   function automatic void qp_plain(input logic [7:0] c);
      if (c == ted_pkg::CH_EQ) begin
         esc_phase = ESC_EQ;
      end else begin
         esc_phase = ESC_TEXT;
         push_byte(c);
      end
   endfunction

   function automatic void qp_char(input logic [7:0] c);
      case (esc_phase)
         ESC_TEXT: qp_plain(c);
         ESC_EQ: begin
            if (c == ted_pkg::CH_CR) begin
               esc_phase = ESC_EQ_CR;
            end else if (c == ted_pkg::CH_LF) begin
               esc_phase = ESC_TEXT;
            end else if (hex_digit(c) >= 0) begin
               held_digit = c;
               esc_phase = ESC_DIGIT;
            end else begin
               push_byte(ted_pkg::CH_EQ);
               qp_plain(c);
            end
         end
         ESC_DIGIT: begin
            if (hex_digit(c) >= 0) begin
               esc_phase = ESC_TEXT;
               push_byte(8'(hex_digit(held_digit) * 16 + hex_digit(c)));
            end else begin
               push_byte(ted_pkg::CH_EQ);
               push_byte(held_digit);
               qp_plain(c);
            end
         end
         default: begin
            esc_phase = ESC_TEXT;
            if (c != ted_pkg::CH_LF) qp_plain(c);
         end
      endcase
   endfunction

   function automatic void b64_char(input logic [7:0] c);
      int v;
      logic [23:0] full;
      v = b64_sextet(c);
      if (pad_seen || v < 0) return;
      if (v == 64) begin
         // padding releases the whole bytes held, then the rest is ignored
         if (sextet_cnt == 2'd2) begin
            push_byte(sextets[11:4]);
         end else if (sextet_cnt == 2'd3) begin
            push_byte(sextets[17:10]);
            push_byte(sextets[9:2]);
         end
         pad_seen = 1'b1;
         sextets = '0;
         sextet_cnt = '0;
      end else if (sextet_cnt == 2'd3) begin
         full = {sextets, 6'(v)};
         push_byte(full[23:16]);
         push_byte(full[15:8]);
         push_byte(full[7:0]);
         sextets = '0;
         sextet_cnt = '0;
      end else begin
         sextets = {sextets[11:0], 6'(v)};
         sextet_cnt = sextet_cnt + 1'b1;
      end
   endfunction

   function automatic void clear_message();
      esc_phase = ESC_TEXT;
      held_digit = '0;
      sextets = '0;
      sextet_cnt = '0;
      pad_seen = 1'b0;
      byte_cnt = '0;
   endfunction

   // results released by one accepted request, left in step_results
   function automatic void decode_char(input logic [7:0] c, input logic last);
      dec_result_type r;
      step_results.delete();
      case (mode_reg)
         ted_pkg::MODE_QP:  qp_char(c);
         ted_pkg::MODE_B64: b64_char(c);
         default:           push_byte(c);
      endcase
      if (last) begin
         // quoted-printable flushes a pending escape literally
         if (mode_reg == ted_pkg::MODE_QP) begin
            if (esc_phase == ESC_EQ) begin
               push_byte(ted_pkg::CH_EQ);
            end else if (esc_phase == ESC_DIGIT) begin
               push_byte(ted_pkg::CH_EQ);
               push_byte(held_digit);
            end
         end
         if (step_results.size() == 0) begin
            r = '{out_byte: 8'h00, byte_valid: 1'b0, run_last: 1'b0, message_end: 1'b0,
                  total_bytes: byte_cnt};
            step_results.push_back(r);
         end
         r = step_results.pop_back();
         r.message_end = 1'b1;
         step_results.push_back(r);
         clear_message();
      end
      if (step_results.size() != 0) begin
         r = step_results.pop_back();
         r.run_last = 1'b1;
         step_results.push_back(r);
      end
   endfunction

   // stimulus table rows
   function automatic stim_row_type req_row(input logic [7:0] c, input logic last);
      stim_row_type r;
      r = '0;
      r.ch = c;
      r.last = last;
      return r;
   endfunction

   function automatic stim_row_type cfg_row(input logic [1:0] m);
      stim_row_type r;
      r = '0;
      r.is_cfg = 1'b1;
      r.mode = m;
      return r;
   endfunction

   function automatic stim_row_type typed_row(input logic [7:0] c, input logic last,
                                              input logic me, input int total);
      stim_row_type r;
      r = req_row(c, last);
      r.typed = 1'b1;
      r.want = '{out_byte: c, byte_valid: 1'b1, run_last: 1'b1, message_end: me,
                 total_bytes: CNT_W'(total)};
      return r;
   endfunction

   // random character helpers
   function automatic logic [7:0] rand_hex_char();
      int v;
      v = $urandom_range(0, 15);
      if (v < 10) return 8'(8'h30 + v);
      return 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 10);
   endfunction

   function automatic logic [7:0] rand_non_hex();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while (hex_digit(c) >= 0 || c == ted_pkg::CH_CR || c == ted_pkg::CH_LF);
      return c;
   endfunction

   function automatic logic [7:0] rand_b64_char();
      int v;
      v = $urandom_range(0, 63);
      if (v < 26) return 8'(8'h41 + v);
      if (v < 52) return 8'(8'h61 + v - 26);
      if (v < 62) return 8'(8'h30 + v - 52);
      return (v == 62) ? 8'h2B : 8'h2F;
   endfunction

   function automatic logic [7:0] rand_b64_junk();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while (b64_sextet(c) != -1);
      return c;
   endfunction

   // one random message for the given mode, left in msg_chars
   function automatic void build_message(input logic [1:0] m);
      int pieces;
      int tail;
      msg_chars.delete();
      if (m == ted_pkg::MODE_QP) begin
         pieces = $urandom_range(1, 6);
         repeat (pieces) begin
            case ($urandom_range(0, 9))
               0, 1: msg_chars.push_back(8'($urandom_range(0, 255)));
               2, 3: msg_chars.push_back(8'($urandom_range(8'h20, 8'h7E)));
               4, 5: begin
                  msg_chars.push_back(ted_pkg::CH_EQ);
                  msg_chars.push_back(rand_hex_char());
                  msg_chars.push_back(rand_hex_char());
               end
               6: begin
                  // soft line breaks
                  msg_chars.push_back(ted_pkg::CH_EQ);
                  case ($urandom_range(0, 2))
                     0: begin
                        msg_chars.push_back(ted_pkg::CH_CR);
                        msg_chars.push_back(ted_pkg::CH_LF);
                     end
                     1: msg_chars.push_back(ted_pkg::CH_CR);
                     default: msg_chars.push_back(ted_pkg::CH_LF);
                  endcase
               end
               7: begin
                  // broken escape
                  msg_chars.push_back(ted_pkg::CH_EQ);
                  if ($urandom_range(0, 1)) msg_chars.push_back(rand_hex_char());
                  msg_chars.push_back(rand_non_hex());
               end
               8: msg_chars.push_back(ted_pkg::CH_EQ);
               default: begin
                  msg_chars.push_back(ted_pkg::CH_EQ);
                  msg_chars.push_back(rand_hex_char());
               end
            endcase
         end
      end else if (m == ted_pkg::MODE_B64) begin
         repeat ($urandom_range(0, 3)) begin
            repeat (4) begin
               if ($urandom_range(0, 7) == 0) msg_chars.push_back(rand_b64_junk());
               msg_chars.push_back(rand_b64_char());
            end
         end
         tail = $urandom_range(0, 4);
         case (tail)
            1: begin
               repeat (2) msg_chars.push_back(rand_b64_char());
               msg_chars.push_back(ted_pkg::CH_EQ);
               if ($urandom_range(0, 1)) msg_chars.push_back(ted_pkg::CH_EQ);
            end
            2: begin
               repeat (3) msg_chars.push_back(rand_b64_char());
               msg_chars.push_back(ted_pkg::CH_EQ);
            end
            3: begin
               repeat ($urandom_range(0, 1)) msg_chars.push_back(rand_b64_char());
               msg_chars.push_back(ted_pkg::CH_EQ);
            end
            4: repeat ($urandom_range(1, 3)) msg_chars.push_back(rand_b64_char());
            default: ;
         endcase
         // characters after the pad are ignored
         if (tail >= 1 && tail <= 3 && $urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 2)) msg_chars.push_back(8'($urandom_range(0, 255)));
         if (msg_chars.size() == 0) msg_chars.push_back(rand_b64_char());
      end else begin
         repeat ($urandom_range(1, 8)) msg_chars.push_back(8'($urandom_range(0, 255)));
      end
   endfunction

   // send one request in bursts with random gaps, predict on acceptance
   task automatic send_request(input logic [7:0] c, input logic last, input logic typed,
                               input dec_result_type want);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
         if (gap != 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req.valid <= 1'b1;
      req.in_byte <= c;
      req.last_byte <= last;
      do @(posedge clock); while (req.ready !== 1'b1);
      decode_char(c, last);
      if (typed) decoded_queue.push_back(want);
      else foreach (step_results[i]) decoded_queue.push_back(step_results[i]);
   endtask

   // stop sending and let every expected result come out
   task automatic wait_drained(input int settle);
      @(negedge clock);
      req.valid <= 1'b0;
      while (decoded_queue.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // mode register write, only with the decoder idle
   task automatic write_mode(input logic [1:0] m);
      wait_drained(SETTLE_CYCLES);
      @(negedge clock);
      csr.valid <= 1'b1;
      csr.decode_mode <= m;
      do @(posedge clock); while (csr.ready !== 1'b1);
      mode_reg = m;
      @(negedge clock);
      csr.valid <= 1'b0;
   endtask

   function automatic void check_field(input string what, input logic [CNT_W-1:0] e,
                                       input logic [CNT_W-1:0] a);
      if (e !== a) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, e, a);
         mismatches++;
      end
   endfunction

   // result checker
   always @(posedge clock) begin : result_check
      dec_result_type got;
      dec_result_type want;
      if (!reset && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
         got = '{out_byte: rsp.out_byte, byte_valid: rsp.byte_valid, run_last: rsp.run_last,
                 message_end: rsp.message_end, total_bytes: rsp.total_bytes};
         if (decoded_queue.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            mismatches++;
         end else begin
            want = decoded_queue.pop_front();
            check_field("out_byte", CNT_W'(want.out_byte), CNT_W'(got.out_byte));
            check_field("byte_valid", CNT_W'(want.byte_valid), CNT_W'(got.byte_valid));
            check_field("run_last", CNT_W'(want.run_last), CNT_W'(got.run_last));
            check_field("message_end", CNT_W'(want.message_end), CNT_W'(got.message_end));
            check_field("total_bytes", want.total_bytes, got.total_bytes);
         end
      end
   end

   // result stalls: always ready, random, or mostly stalled, in stretches
   always @(negedge clock) begin : rsp_stall
      int pattern;
      int stretch;
      if (stretch == 0) begin
         pattern = $urandom_range(0, 2);
         stretch = $urandom_range(8, 40);
      end
      stretch--;
      case (pattern)
         0: rsp.ready <= 1'b1;
         1: rsp.ready <= 1'($urandom_range(0, 1));
         default: rsp.ready <= ($urandom_range(0, 5) == 0);
      endcase
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("transfer_encoding_decoder test failed");
         $finish;
      end
   end

   initial begin : stimulus
      stim_row_type rows [0:DIRECTED_ROWS-1];
      logic [1:0]   phase_modes [4];
      logic [1:0]   m;
      int           sent;
      int           phase;
      int           n_msgs;
      logic         cut;

      req.valid = 1'b0;
      req.in_byte = 8'h00;
      req.last_byte = 1'b0;
      csr.valid = 1'b0;
      csr.decode_mode = ted_pkg::MODE_PASS;
      mode_reg = ted_pkg::MODE_PASS;
      clear_message();

      // reset
      reset = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part
      rows = '{
         // pass-through after reset: extremes and the zero character
         typed_row(8'hFF, 1'b0, 1'b0, 1),
         typed_row(8'h00, 1'b0, 1'b0, 2),
         typed_row(8'h01, 1'b1, 1'b1, 3),
         cfg_row(ted_pkg::MODE_QP),
         // "=41", then "=fF" with mixed case
         req_row(ted_pkg::CH_EQ, 1'b0), req_row(8'h34, 1'b0), req_row(8'h31, 1'b0),
         req_row(ted_pkg::CH_EQ, 1'b0), req_row(8'h66, 1'b0), req_row(8'h46, 1'b0),
         // soft breaks, CRLF and bare LF
         req_row(ted_pkg::CH_EQ, 1'b0), req_row(ted_pkg::CH_CR, 1'b0),
         req_row(ted_pkg::CH_LF, 1'b0),
         req_row(ted_pkg::CH_EQ, 1'b0), req_row(ted_pkg::CH_LF, 1'b0),
         // broken escapes, the second one broken by a new '='
         req_row(ted_pkg::CH_EQ, 1'b0), req_row(8'h5A, 1'b0),
         req_row(ted_pkg::CH_EQ, 1'b0), req_row(8'h61, 1'b0), req_row(ted_pkg::CH_EQ, 1'b0),
         // pending '=' and digit flushed on the last byte
         req_row(8'h62, 1'b1),
         cfg_row(ted_pkg::MODE_B64),
         // "TWFu" then junk, "TW=" and an ignored byte after the pad
         req_row(8'h54, 1'b0), req_row(8'h57, 1'b0), req_row(8'h46, 1'b0),
         req_row(8'h75, 1'b0), req_row(8'h21, 1'b0), req_row(8'h54, 1'b0),
         req_row(8'h57, 1'b0), req_row(ted_pkg::CH_EQ, 1'b0), req_row(8'h78, 1'b1)
      };
      foreach (rows[i]) begin
         if (rows[i].is_cfg) write_mode(rows[i].mode);
         else send_request(rows[i].ch, rows[i].last, rows[i].typed, rows[i].want);
      end

      // random part: phases of messages, sometimes cut short across a mode change
      phase_modes = '{ted_pkg::MODE_QP, MODE_ALT_PASS, ted_pkg::MODE_B64, ted_pkg::MODE_PASS};
      sent = 0;
      phase = 0;
      while (sent < RANDOM_REQUESTS) begin
         if (phase < 4) m = phase_modes[phase];
         else if ($urandom_range(0, 4) == 0) m = 2'($urandom_range(0, 3));
         else m = $urandom_range(0, 1) ? ted_pkg::MODE_QP : ted_pkg::MODE_B64;
         write_mode(m);
         n_msgs = $urandom_range(1, 4);
         for (int k = 0; k < n_msgs; k++) begin
            cut = (k == n_msgs - 1) && ($urandom_range(0, 3) == 0);
            build_message(m);
            foreach (msg_chars[j]) begin
               send_request(msg_chars[j], (j == msg_chars.size() - 1) && !cut, 1'b0, '0);
               sent++;
            end
         end
         phase++;
      end

      // close any message left open, then drain
      send_request(8'h41, 1'b1, 1'b0, '0);
      wait_drained(10);
      if (mismatches == 0) $display("transfer_encoding_decoder test passed");
      else $display("transfer_encoding_decoder test failed");
      $finish;
   end

endmodule
